/* design/hcfr_pkg.sv */
// Shared types, constants and the CRC-8 step for the HDLC CRC-8 frame receiver.
package hcfr_pkg;

  // Line coding
  localparam logic [7:0] FlagByte = 8'h7E;
  localparam logic [7:0] EscByte  = 8'h7D;
  localparam logic [7:0] EscXor   = 8'h20;

  // CRC-8, MSB first, init 0, no final XOR
  localparam logic [7:0] CrcPoly  = 8'h2F;

  // Frame layout, in un-stuffed byte positions
  localparam logic [9:0] MinFrame     = 10'd8;
  localparam logic [9:0] PayloadStart = 10'd7;
  localparam logic [9:0] ProfileStart = 10'd5;
  localparam logic [9:0] FlagsStart   = 10'd1;
  localparam logic [9:0] CountMax     = 10'd1023;

  // Header values of a valid frame
  localparam logic [7:0]  VersionOne = 8'd1;
  localparam logic [15:0] ProfileMin = 16'd1;
  localparam logic [15:0] ProfileMax = 16'd3;

  // Request type codes
  localparam logic [1:0] ReqRead      = 2'd0;
  localparam logic [1:0] ReqWrite     = 2'd1;
  localparam logic [1:0] ReqWriteRead = 2'd2;

  // Reset value of the payload limit register
  localparam logic [8:0] LimitReset = 9'd256;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef logic [8:0] limit_t;

  typedef struct packed {
    logic       write_enable;
    logic [7:0] write_index;
    logic [7:0] write_data;
    logic       frame_done;
    logic       frame_ok;
    logic [1:0] frame_profile;
    logic [1:0] req_kind;
    logic       notify_flag;
    logic [8:0] pay_len;
  } result_t;

  // One byte through the CRC-8, MSB first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] c;
    c = crc ^ d;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

/* design/hcfr_stream_if.sv */
// Valid/ready channel carrying one payload of a given type.
interface hcfr_stream_if #(
  parameter type T_t = logic
);
  logic valid;
  logic ready;
  T_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/hcfr_frame_core.sv */
// Frame state and per-byte un-stuffing, header capture, CRC and frame check.
module hcfr_frame_core #(
  parameter int PAYLOAD_CAPACITY = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  hcfr_pkg::limit_t limit_i,
  output hcfr_pkg::result_t res_o
);
  import hcfr_pkg::*;

  // Capacity clamped to what the 9-bit limit can reach
  localparam logic [8:0] LimitCap = (PAYLOAD_CAPACITY > 511) ? 9'd511 : 9'(PAYLOAD_CAPACITY);

  logic        esc_q, esc_d;
  logic        drop_q, drop_d;
  logic [9:0]  count_q, count_d;
  logic [7:0]  version_q, version_d;
  logic [31:0] flag_q, flag_d;
  logic [15:0] prof_q, prof_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  held_q, held_d;

  logic [8:0]  lim_eff;
  logic [7:0]  d;
  logic [9:0]  pos;
  logic [1:0]  flag_idx;
  logic        good;
  logic [8:0]  plen;

  assign lim_eff  = (limit_i > LimitCap) ? LimitCap : limit_i;
  assign d        = esc_q ? (byte_i ^ EscXor) : byte_i;
  assign pos      = count_q - PayloadStart;
  assign flag_idx = count_q[1:0] - 2'd1;
  assign plen     = 9'(count_q - MinFrame);

  // Frame check on the state left by the previous bytes
  assign good = !drop_q && !esc_q && (version_q == VersionOne) && flag_q[1] &&
                (flag_q[31:3] == '0) && (prof_q >= ProfileMin) &&
                (prof_q <= ProfileMax) && (count_q >= MinFrame) && (crc_q == '0);

  // Next state and result of the byte at the input register
  always_comb begin
    esc_d     = esc_q;
    drop_d    = drop_q;
    count_d   = count_q;
    version_d = version_q;
    flag_d    = flag_q;
    prof_d    = prof_q;
    crc_d     = crc_q;
    held_d    = held_q;
    res_o     = '0;

    priority if (byte_i == FlagByte) begin
      res_o.frame_done = 1'b1;
      if (good) begin
        res_o.frame_ok      = 1'b1;
        res_o.frame_profile = prof_q[1:0];
        res_o.pay_len       = plen;
        res_o.notify_flag   = flag_q[2];
        if (flag_q[0]) begin
          res_o.req_kind = (plen != '0) ? ReqWriteRead : ReqRead;
        end else begin
          res_o.req_kind = ReqWrite;
        end
      end
      esc_d     = 1'b0;
      drop_d    = 1'b0;
      count_d   = '0;
      version_d = '0;
      flag_d    = '0;
      prof_d    = '0;
      crc_d     = '0;
      held_d    = '0;
    end else if (drop_q) begin
      esc_d = 1'b0;
    end else if (byte_i == EscByte) begin
      if (esc_q) begin
        drop_d = 1'b1;
        esc_d  = 1'b0;
      end else begin
        esc_d = 1'b1;
      end
    end else begin
      esc_d = 1'b0;
      priority if (count_q >= PayloadStart) begin
        if (pos > {1'b0, lim_eff}) begin
          drop_d = 1'b1;
        end else begin
          // commit the previous byte; the newest may be the checksum
          if (pos != '0) begin
            res_o.write_enable = 1'b1;
            res_o.write_index  = 8'(pos - 10'd1);
            res_o.write_data   = held_q;
          end
          held_d = d;
        end
      end else if (count_q >= ProfileStart) begin
        if (count_q == ProfileStart) begin
          prof_d[7:0] = prof_q[7:0] | d;
        end else begin
          prof_d[15:8] = prof_q[15:8] | d;
        end
      end else if (count_q >= FlagsStart) begin
        flag_d[8*flag_idx +: 8] = flag_q[8*flag_idx +: 8] | d;
      end else begin
        version_d = d;
      end
      if (!drop_d) begin
        if (count_q < CountMax) begin
          count_d = count_q + 10'd1;
        end
        crc_d = crc8_update(crc_q, d);
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q   <= 1'b0;
      drop_q  <= 1'b0;
      count_q <= '0;
    end else if (step_i) begin
      esc_q   <= esc_d;
      drop_q  <= drop_d;
      count_q <= count_d;
    end
  end

  // Header, CRC and held byte; cleared by reset since an empty frame reads them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= '0;
      flag_q    <= '0;
      prof_q    <= '0;
      crc_q     <= '0;
      held_q    <= '0;
    end else if (step_i) begin
      version_q <= version_d;
      flag_q    <= flag_d;
      prof_q    <= prof_d;
      crc_q     <= crc_d;
      held_q    <= held_d;
    end
  end

  a_ok_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.frame_ok |-> res_o.frame_done)
    else $error("frame_ok without frame_done");

  a_no_write_on_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.write_enable |-> !res_o.frame_done)
    else $error("payload write on a flag byte");

  a_flag_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && byte_i == FlagByte) |=> (count_q == '0) && !drop_q && !esc_q && (crc_q == '0))
    else $error("frame state not cleared after flag");

  a_drop_no_escape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |-> !esc_q)
    else $error("escape pending in a dropped frame");

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(count_q) && $stable(crc_q) && $stable(held_q))
    else $error("frame state moved without a step");

endmodule

/* design/hdlc_crc8_frame_receiver.sv */
// Top level: input register, frame core, result register and limit register.
//
// Usage:
//   rx_i  (sink)  : one raw line byte per transaction, field rx_byte.
//   res_o (source): one result per accepted byte: payload write strobe,
//                   index and data, and on a flag byte the frame verdict
//                   with profile, request type, notify bit and length.
//   cfg_i (sink)  : writes payload_limit (9 bits); always ready. Write it
//                   only while no byte is in flight.
// Path: a byte accepted on rx_i is registered in the input register,
//   processed by the frame core and held in the result register for res_o.
// Throughput: one byte per cycle while res_o is taken; the frame state
//   update for a byte fits between the input and result registers.
// Stall: when res_o is not taken, the result register holds and the byte
//   in the input register waits; rx_i drops ready once both are full.
// Reset: all frame state clears, payload_limit returns to 256, both
//   registers empty.
module hdlc_crc8_frame_receiver #(
  parameter int PAYLOAD_CAPACITY = 256
) (
  input logic clk_i,
  input logic rst_ni,
  hcfr_stream_if.sink   rx_i,
  hcfr_stream_if.sink   cfg_i,
  hcfr_stream_if.source res_o
);
  import hcfr_pkg::*;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  result_t    res_q;
  result_t    res_d;
  limit_t     limit_q;
  logic       out_load;
  logic       step;

  assign out_load   = !out_vld_q || res_o.ready;
  assign step       = in_vld_q && out_load;
  assign rx_i.ready = !in_vld_q || step;
  assign cfg_i.ready = 1'b1;

  // Limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.data;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.data.rx_byte;
    end
  end

  hcfr_frame_core #(
    .PAYLOAD_CAPACITY(PAYLOAD_CAPACITY)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .limit_i(limit_q),
    .res_o  (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = out_vld_q;
  assign res_o.data  = res_q;

endmodule

/* bench/hdlc_crc8_frame_receiver_tb.sv */
// Self-checking testbench for the HDLC CRC-8 frame receiver: stuffed frames in, verdicts checked.
`timescale 1ns / 1ps

module hdlc_crc8_frame_receiver_tb;
  import hcfr_pkg::*;

  localparam int          PayloadCapacity = 256;
  localparam int          ClkPeriod       = 10;
  localparam int          RandomItems     = 1600;
  localparam int          NumPhases       = 6;
  localparam int          DrainCycles     = 8;
  localparam int          HoldOffAt       = 300;
  localparam int          HoldOffCycles   = 200;
  localparam int unsigned CycleLimit      = 400000;

  typedef enum int {
    FaultNone,
    FaultCrc,
    FaultVersion,
    FaultFlags,
    FaultProfile,
    FaultDoubleEsc,
    FaultEscFlag,
    FaultShort,
    FaultCount
  } fault_e;

  // CRC-8 step, one data bit at a time, MSB first
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ d[i];
      c = {c[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return c;
  endfunction

  // Tracks frame decoding state and holds the results expected from the block
  class frame_result_tracker;
    int unsigned cap_bytes;
    limit_t      limit;
    bit          esc;
    bit          dropping;
    logic [9:0]  count;
    logic [7:0]  version;
    logic [31:0] flags;
    logic [15:0] profile;
    logic [7:0]  crc;
    logic [7:0]  held;
    result_t     pending[$];
    int unsigned errors;

    function new(int unsigned capacity);
      cap_bytes = capacity;
      limit = LimitReset;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      esc = 1'b0;
      dropping = 1'b0;
      count = '0;
      version = '0;
      flags = '0;
      profile = '0;
      crc = '0;
      held = '0;
    endfunction

    // Decode one accepted line byte and queue the result it should produce
    function void note_byte(logic [7:0] b);
      result_t     r;
      logic [7:0]  d;
      logic [9:0]  pos;
      int unsigned eff;
      bit          good;
      r = '0;
      d = b;
      if (d == FlagByte) begin
        good = !dropping && !esc && version == VersionOne && flags[1] && flags[31:3] == '0 &&
               profile >= ProfileMin && profile <= ProfileMax && count >= MinFrame &&
               crc == 8'h00;
        r.frame_done = 1'b1;
        if (good) begin
          r.frame_ok = 1'b1;
          r.frame_profile = profile[1:0];
          r.pay_len = 9'(count - MinFrame);
          r.notify_flag = flags[2];
          if (flags[0]) begin
            r.req_kind = (r.pay_len != '0) ? ReqWriteRead : ReqRead;
          end else begin
            r.req_kind = ReqWrite;
          end
        end
        clear_frame();
      end else if (dropping) begin
        esc = 1'b0;
      end else if (d == EscByte) begin
        if (esc) begin
          dropping = 1'b1;
          esc = 1'b0;
        end else begin
          esc = 1'b1;
        end
      end else begin
        if (esc) begin
          d = d ^ EscXor;
          esc = 1'b0;
        end
        if (count >= PayloadStart) begin
          pos = count - PayloadStart;
          eff = (limit > cap_bytes) ? cap_bytes : limit;
          if (pos > eff) begin
            dropping = 1'b1;
          end else begin
            // payload goes out one byte late so the checksum is never written
            if (pos != '0) begin
              r.write_enable = 1'b1;
              r.write_index = 8'(pos - 10'd1);
              r.write_data = held;
            end
            held = d;
          end
        end else if (count >= ProfileStart) begin
          profile = profile | 16'(32'(d) << (8 * (count - ProfileStart)));
        end else if (count >= FlagsStart) begin
          flags = flags | (32'(d) << (8 * (count - FlagsStart)));
        end else begin
          version = d;
        end
        if (!dropping) begin
          if (count < CountMax) begin
            count = count + 10'd1;
          end
          crc = crc8_next(crc, d);
        end
      end
      pending.push_back(r);
    endfunction

    function void report(string field, logic [8:0] want, logic [8:0] got);
      errors++;
      if (errors <= 50) begin
        $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 50) begin
          $display("%0t: result %0h with no byte outstanding, expected none", $time, got);
        end
        return;
      end
      want = pending.pop_front();
      if (got.write_enable !== want.write_enable)
        report("write_enable", want.write_enable, got.write_enable);
      if (got.write_index !== want.write_index)
        report("write_index", want.write_index, got.write_index);
      if (got.write_data !== want.write_data)
        report("write_data", want.write_data, got.write_data);
      if (got.frame_done !== want.frame_done)
        report("frame_done", want.frame_done, got.frame_done);
      if (got.frame_ok !== want.frame_ok)
        report("frame_ok", want.frame_ok, got.frame_ok);
      if (got.frame_profile !== want.frame_profile)
        report("frame_profile", want.frame_profile, got.frame_profile);
      if (got.req_kind !== want.req_kind)
        report("req_kind", want.req_kind, got.req_kind);
      if (got.notify_flag !== want.notify_flag)
        report("notify_flag", want.notify_flag, got.notify_flag);
      if (got.pay_len !== want.pay_len)
        report("pay_len", want.pay_len, got.pay_len);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  bit          src_pacing = 1'b1;
  bit          sink_pacing = 1'b1;

  frame_result_tracker tracker = new(PayloadCapacity);

  hcfr_stream_if #(.T_t(rx_item_t)) rx_ch ();
  hcfr_stream_if #(.T_t(limit_t))   cfg_ch ();
  hcfr_stream_if #(.T_t(result_t))  res_ch ();

  hdlc_crc8_frame_receiver #(
    .PAYLOAD_CAPACITY(PayloadCapacity)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .rx_i  (rx_ch),
    .cfg_i (cfg_ch),
    .res_o (res_ch)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // Watchdog
  initial begin
    wait (cycles >= CycleLimit);
    $display("Mismatches found");
    $finish;
  end

  // Reset and initial input levels
  initial begin
    rst_n <= 1'b0;
    rx_ch.valid <= 1'b0;
    rx_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Result side: random stalls, one long hold-off to back up the input
  initial begin
    int gap;
    int taken;
    taken = 0;
    res_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken == HoldOffAt) begin
        gap = HoldOffCycles;
      end else begin
        gap = sink_pacing ? $urandom_range(0, 6) : 0;
      end
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      tracker.check_result(res_ch.data);
      taken++;
      if (taken % 64 == 0) begin
        sink_pacing = $urandom_range(0, 3) != 0;
      end
    end
  end

  // One raw line byte, one transaction
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = src_pacing ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.data <= b;
    do @(posedge clk); while (!rx_ch.ready);
    tracker.note_byte(b);
    bytes_sent++;
  endtask

  // Byte stuffing; ordinary bytes get escaped now and then too
  task automatic send_stuffed(logic [7:0] b);
    logic [7:0] x;
    x = b ^ EscXor;
    if (b == FlagByte || b == EscByte ||
        (x != FlagByte && x != EscByte && $urandom_range(0, 15) == 0)) begin
      send_byte(EscByte);
      send_byte(x);
    end else begin
      send_byte(b);
    end
  endtask

  function automatic logic [7:0] pick_payload_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return FlagByte;
    if (r == 1) return EscByte;
    return 8'($urandom_range(0, 255));
  endfunction

  // Build header, payload and checksum, inject the fault, send, close with a flag
  task automatic send_frame(int unsigned n, fault_e fault);
    logic [7:0]  body[$];
    logic [7:0]  ver;
    logic [7:0]  crc;
    logic [31:0] flags;
    logic [15:0] prof;
    int unsigned at;
    int unsigned keep;
    ver = VersionOne;
    flags = {29'd0, 1'($urandom_range(0, 1)), 1'b1, 1'($urandom_range(0, 1))};
    prof = 16'($urandom_range(ProfileMin, ProfileMax));
    case (fault)
      FaultVersion: ver = VersionOne ^ 8'($urandom_range(1, 255));
      FaultFlags: begin
        if ($urandom_range(0, 3) == 0) begin
          flags[1] = 1'b0;
        end else begin
          flags[$urandom_range(3, 31)] = 1'b1;
        end
      end
      FaultProfile: prof = ($urandom_range(0, 1) != 0) ? 16'd0 : 16'($urandom_range(4, 65535));
      default: ;
    endcase
    body.push_back(ver);
    for (int k = 0; k < 4; k++) body.push_back(flags[8*k +: 8]);
    body.push_back(prof[7:0]);
    body.push_back(prof[15:8]);
    repeat (n) body.push_back(pick_payload_byte());
    crc = 8'h00;
    foreach (body[i]) crc = crc8_next(crc, body[i]);
    body.push_back(crc);
    if (fault == FaultCrc) begin
      at = $urandom_range(0, body.size() - 1);
      body[at] = body[at] ^ 8'(1 << $urandom_range(0, 7));
    end
    if (fault == FaultShort) begin
      keep = $urandom_range(0, 7);
      while (body.size() > keep) void'(body.pop_back());
    end
    at = (body.size() > 0) ? $urandom_range(0, body.size() - 1) : 0;
    foreach (body[i]) begin
      if (fault == FaultDoubleEsc && i == at) begin
        send_byte(EscByte);
        send_byte(EscByte);
      end
      send_stuffed(body[i]);
    end
    if (fault == FaultEscFlag) begin
      send_byte(EscByte);
    end
    send_byte(FlagByte);
  endtask

  // Stop offering bytes, wait until every expected result is in, then let the pipeline empty
  task automatic settle();
    rx_ch.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    limit_t      phase_limits[NumPhases];
    int unsigned phase_end;
    int unsigned eff;
    int unsigned n;
    int          kind;
    int          r;
    fault_e      fault;

    phase_limits = '{9'd256, 9'd0, 9'd511, 9'd5, 9'd0, 9'd256};
    phase_limits[4] = 9'($urandom_range(6, 255));

    wait (rst_n === 1'b1);
    @(posedge clk);

    // Directed: idle flag, minimal frame, double escape with ignored byte,
    // flag right after an escape, checksum error
    src_pacing = 1'b0;
    send_byte(FlagByte);
    send_frame(0, FaultNone);
    send_byte(EscByte);
    send_byte(EscByte);
    send_byte(8'hFF);
    send_byte(FlagByte);
    send_byte(8'h00);
    send_byte(EscByte);
    send_byte(FlagByte);
    send_frame(0, FaultCrc);

    // Random frames over several limit settings
    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      cfg_ch.valid <= 1'b1;
      cfg_ch.data <= phase_limits[ph];
      do @(posedge clk); while (!cfg_ch.ready);
      cfg_ch.valid <= 1'b0;
      tracker.limit = phase_limits[ph];
      eff = (phase_limits[ph] > PayloadCapacity) ? PayloadCapacity : phase_limits[ph];

      phase_end = bytes_sent + RandomItems / NumPhases;
      while (bytes_sent < phase_end) begin
        src_pacing = $urandom_range(0, 3) != 0;
        kind = $urandom_range(0, 19);
        if (kind < 3) begin
          // line noise, closed by a flag
          repeat ($urandom_range(1, 10)) begin
            r = $urandom_range(0, 7);
            send_byte(r == 0 ? FlagByte : r == 1 ? EscByte : 8'($urandom_range(0, 255)));
          end
          send_byte(FlagByte);
        end else if (kind < 5) begin
          repeat ($urandom_range(1, 3)) send_byte(FlagByte);
        end else begin
          r = $urandom_range(0, 39);
          if (r == 0) begin
            n = eff + $urandom_range(0, 1);
          end else if (r < 4) begin
            n = $urandom_range(0, (eff + 1 < 20) ? eff + 1 : 20);
          end else begin
            n = $urandom_range(0, 12);
          end
          fault = ($urandom_range(0, 4) < 3) ? FaultNone
                                             : fault_e'($urandom_range(1, FaultCount - 1));
          if ($urandom_range(0, 1) != 0) begin
            send_byte(FlagByte);
          end
          send_frame(n, fault);
        end
      end
    end
    rx_ch.valid <= 1'b0;

    settle();
    if (tracker.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* hdlc_crc8_frame_receiver.f */
design/hcfr_pkg.sv
design/hcfr_stream_if.sv
design/hcfr_frame_core.sv
design/hdlc_crc8_frame_receiver.sv
bench/hdlc_crc8_frame_receiver_tb.sv
